@@ rtl/core/sha1_pkg.sv @@
// ----------------------------------------------------------------------------
// sha1_pkg
// shared types, constants and round functions of the sha-1 digest block
// ----------------------------------------------------------------------------
package sha1_pkg;

	localparam int WORD_W  = 32;
	localparam int BLK_WORDS = 16;
	localparam int HASH_WORDS = 5;
	localparam int COUNT_W = 61;
	localparam int RND_W   = 7;
	localparam int IDX_W   = 3;

	localparam logic [RND_W-1:0] ROUND_LAST = 7'd79;
	localparam logic [5:0]       POS_LAST   = 6'd63;
	localparam logic [5:0]       POS_LEN    = 6'd56;
	localparam logic [7:0]       PAD_BYTE   = 8'h80;
	localparam logic [IDX_W-1:0] IDX_LAST   = 3'd4;

	localparam logic [WORD_W-1:0] IV [HASH_WORDS] = '{
		32'h67452301, 32'hEFCDAB89, 32'h98BADCFE, 32'h10325476, 32'hC3D2E1F0
	};

	localparam logic [WORD_W-1:0] K0 = 32'h5A827999;
	localparam logic [WORD_W-1:0] K1 = 32'h6ED9EBA1;
	localparam logic [WORD_W-1:0] K2 = 32'h8F1BBCDC;
	localparam logic [WORD_W-1:0] K3 = 32'hCA62C1D6;

	// commands from the controller to the datapath
	typedef struct packed {
		logic take;   // input item accepted
		logic start;  // load working variables from chain value
		logic round;  // run one round
		logic feed;   // feed-forward add, clear block
		logic pad;    // place the 0x80 marker
		logic len;    // place the bit length
		logic done;   // move digest out, restart chain
	} sha1_cmd_t;

	typedef struct packed {
		logic pos_last;    // next byte lands in the last slot of the block
		logic pos_ge56;    // no room left for the length field
		logic last_round;
		logic out_busy;
	} sha1_stat_t;

	function automatic logic [WORD_W-1:0] rol(input logic [WORD_W-1:0] x, input int n);
		rol = (x << n) | (x >> (WORD_W - n));
	endfunction

	function automatic logic [WORD_W-1:0] round_k(input logic [RND_W-1:0] r);
		if (r < 7'd20)      round_k = K0;
		else if (r < 7'd40) round_k = K1;
		else if (r < 7'd60) round_k = K2;
		else                round_k = K3;
	endfunction

	function automatic logic [WORD_W-1:0] round_f(input logic [RND_W-1:0] r,
		input logic [WORD_W-1:0] b, input logic [WORD_W-1:0] c,
		input logic [WORD_W-1:0] d);
		if (r < 7'd20)
			round_f = (b & c) ^ (~b & d);
		else if (r >= 7'd40 && r < 7'd60)
			round_f = (b & c) ^ (b & d) ^ (c & d);
		else
			round_f = b ^ c ^ d;
	endfunction

endpackage

@@ rtl/core/sha1_ctrl.sv @@
// ----------------------------------------------------------------------------
// sha1_ctrl
// sequencer for byte intake, compression runs, padding and digest hand-off
// ----------------------------------------------------------------------------
module sha1_ctrl
	import sha1_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	input  logic       in_present,
	input  logic       in_finish,
	output logic       in_ready,
	input  sha1_stat_t stat,
	output sha1_cmd_t  cmd
);

	typedef enum logic [5:0] {
		S_IDLE  = 6'b000001,
		S_ROUND = 6'b000010,
		S_FEED  = 6'b000100,
		S_PAD   = 6'b001000,
		S_LEN   = 6'b010000,
		S_DONE  = 6'b100000
	} state_t;

	// which block the current compression belongs to
	typedef enum logic [1:0] {
		PH_MSG = 2'd0,
		PH_PAD = 2'd1,
		PH_LEN = 2'd2
	} phase_t;

	state_t state_q, state_d;
	phase_t phase_q, phase_d;
	logic   fin_q, fin_d;
	logic   accept;

	assign in_ready = (state_q == S_IDLE);
	assign accept   = in_valid && in_ready;

	always_comb begin
		state_d   = state_q;
		phase_d   = phase_q;
		fin_d     = fin_q;
		cmd       = '0;
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					cmd.take = 1'b1;
					fin_d    = in_finish;
					if (in_present && stat.pos_last) begin
						cmd.start = 1'b1;
						phase_d   = PH_MSG;
						state_d   = S_ROUND;
					end else if (in_finish) begin
						state_d = S_PAD;
					end
				end
			end
			S_ROUND: begin
				cmd.round = 1'b1;
				if (stat.last_round) state_d = S_FEED;
			end
			S_FEED: begin
				cmd.feed = 1'b1;
				unique case (phase_q)
					PH_MSG:  state_d = fin_q ? S_PAD : S_IDLE;
					PH_PAD:  state_d = S_LEN;
					PH_LEN:  state_d = S_DONE;
					default: state_d = S_IDLE;
				endcase
			end
			S_PAD: begin
				cmd.pad = 1'b1;
				if (stat.pos_ge56) begin
					cmd.start = 1'b1;
					phase_d   = PH_PAD;
					state_d   = S_ROUND;
				end else begin
					state_d = S_LEN;
				end
			end
			S_LEN: begin
				cmd.len   = 1'b1;
				cmd.start = 1'b1;
				phase_d   = PH_LEN;
				state_d   = S_ROUND;
			end
			S_DONE: begin
				// hold until the previous digest has drained
				if (!stat.out_busy) begin
					cmd.done = 1'b1;
					fin_d    = 1'b0;
					state_d  = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			phase_q <= PH_MSG;
			fin_q   <= 1'b0;
		end else begin
			state_q <= state_d;
			phase_q <= phase_d;
			fin_q   <= fin_d;
		end
	end

endmodule

@@ rtl/core/sha1_dp.sv @@
// ----------------------------------------------------------------------------
// sha1_dp
// block buffer with schedule window, round unit, chain value and digest output
// ----------------------------------------------------------------------------
module sha1_dp
	import sha1_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  sha1_cmd_t         cmd,
	output sha1_stat_t        stat,
	input  logic [7:0]        in_byte,
	input  logic              in_present,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [WORD_W-1:0] out_word,
	output logic [IDX_W-1:0]  out_index,
	output logic              out_last
);

	logic [WORD_W-1:0]  w_q     [BLK_WORDS];
	logic [WORD_W-1:0]  chain_q [HASH_WORDS];
	logic [WORD_W-1:0]  var_q   [HASH_WORDS];
	logic [WORD_W-1:0]  dig_q   [HASH_WORDS];
	logic [COUNT_W-1:0] count_q;
	logic [RND_W-1:0]   rnd_q;
	logic [IDX_W-1:0]   idx_q;
	logic               busy_q;

	logic [5:0]          pos;
	logic [3:0]          widx;
	logic [1:0]          lane;
	logic [WORD_W-1:0]   w_next;
	logic [WORD_W-1:0]   t_sum;
	logic [2*WORD_W-1:0] bit_len;
	logic                put_en;
	logic [7:0]          put_val;

	assign pos     = count_q[5:0];
	assign widx    = pos[5:2];
	assign lane    = pos[1:0];
	assign bit_len = {count_q, 3'b000};
	assign put_en  = (cmd.take && in_present) || cmd.pad;
	assign put_val = cmd.pad ? PAD_BYTE : in_byte;

	// window holds w[t..t+15]; w[t+16] is formed from fixed taps
	assign w_next = rol(w_q[13] ^ w_q[8] ^ w_q[2] ^ w_q[0], 1);
	assign t_sum  = rol(var_q[0], 5) + round_f(rnd_q, var_q[1], var_q[2], var_q[3])
		+ var_q[4] + w_q[0] + round_k(rnd_q);

	assign stat.pos_last   = (pos == POS_LAST);
	assign stat.pos_ge56   = (pos >= POS_LEN);
	assign stat.last_round = (rnd_q == ROUND_LAST);
	assign stat.out_busy   = busy_q;

	assign out_valid = busy_q;
	assign out_word  = dig_q[0];
	assign out_index = idx_q;
	assign out_last  = (idx_q == IDX_LAST);

	// message block
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < BLK_WORDS; i++) w_q[i] <= '0;
		end else if (cmd.round) begin
			for (int i = 0; i < BLK_WORDS - 1; i++) w_q[i] <= w_q[i+1];
			w_q[BLK_WORDS-1] <= w_next;
		end else if (cmd.feed) begin
			for (int i = 0; i < BLK_WORDS; i++) w_q[i] <= '0;
		end else if (cmd.len) begin
			w_q[14] <= bit_len[2*WORD_W-1:WORD_W];
			w_q[15] <= bit_len[WORD_W-1:0];
		end else if (put_en) begin
			unique case (lane)
				2'd0: w_q[widx][31:24] <= put_val;
				2'd1: w_q[widx][23:16] <= put_val;
				2'd2: w_q[widx][15:8]  <= put_val;
				2'd3: w_q[widx][7:0]   <= put_val;
				default: ;
			endcase
		end
	end

	// byte count and round counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			rnd_q   <= '0;
		end else begin
			if (cmd.done)
				count_q <= '0;
			else if (cmd.take && in_present)
				count_q <= count_q + COUNT_W'(1);
			if (cmd.feed)
				rnd_q <= '0;
			else if (cmd.round)
				rnd_q <= rnd_q + RND_W'(1);
		end
	end

	// working variables
	always_ff @(posedge clk) begin
		if (cmd.start) begin
			for (int i = 0; i < HASH_WORDS; i++) var_q[i] <= chain_q[i];
		end else if (cmd.round) begin
			var_q[0] <= t_sum;
			var_q[1] <= var_q[0];
			var_q[2] <= rol(var_q[1], 30);
			var_q[3] <= var_q[2];
			var_q[4] <= var_q[3];
		end
	end

	// chain value
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < HASH_WORDS; i++) chain_q[i] <= IV[i];
		end else if (cmd.feed) begin
			for (int i = 0; i < HASH_WORDS; i++) chain_q[i] <= chain_q[i] + var_q[i];
		end else if (cmd.done) begin
			for (int i = 0; i < HASH_WORDS; i++) chain_q[i] <= IV[i];
		end
	end

	// digest buffer, drained one word per item
	always_ff @(posedge clk) begin
		if (cmd.done) begin
			for (int i = 0; i < HASH_WORDS; i++) dig_q[i] <= chain_q[i];
		end else if (busy_q && out_ready) begin
			for (int i = 0; i < HASH_WORDS - 1; i++) dig_q[i] <= dig_q[i+1];
			dig_q[HASH_WORDS-1] <= dig_q[HASH_WORDS-1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			idx_q  <= '0;
		end else if (cmd.done) begin
			busy_q <= 1'b1;
			idx_q  <= '0;
		end else if (busy_q && out_ready) begin
			idx_q <= idx_q + IDX_W'(1);
			if (out_last) busy_q <= 1'b0;
		end
	end

endmodule

@@ rtl/core/sha1_message_digest.sv @@
// ----------------------------------------------------------------------------
// sha1_message_digest
// sha-1 over a byte stream, five digest words out per message
// ----------------------------------------------------------------------------
//  channel | dir | tdata (low bit up) | tuser (low bit up) | tlast
//  s_      | in  | data_byte[7:0]     | byte_present       | end_of_message
//  m_      | out | digest_word[31:0]  | word_index[2:0]    | last_word
//
//  a plain byte item is taken while idle; a byte that fills a block starts a
//  compression (80 rounds at one per cycle in the round unit, plus the feed-forward add)
//  end of message adds padding, length and digest steps around one or two
//  compressions, the second when the length needs an extra block,
//  before the digest moves to the output buffer
//  the output buffer drains while the next message is taken in; a new digest
//  waits for it to empty. reset restores the initial chain value
// ----------------------------------------------------------------------------
module sha1_message_digest
	import sha1_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // data_byte
	input  logic [0:0]  s_tuser,   // byte_present
	input  logic        s_tlast,   // end_of_message
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,   // digest_word
	output logic [2:0]  m_tuser,   // word_index
	output logic        m_tlast    // last_word
);

	sha1_cmd_t  cmd;
	sha1_stat_t stat;

	sha1_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (s_tvalid),
		.in_present (s_tuser[0]),
		.in_finish  (s_tlast),
		.in_ready   (s_tready),
		.stat       (stat),
		.cmd        (cmd)
	);

	sha1_dp u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.stat       (stat),
		.in_byte    (s_tdata),
		.in_present (s_tuser[0]),
		.out_valid  (m_tvalid),
		.out_ready  (m_tready),
		.out_word   (m_tdata),
		.out_index  (m_tuser),
		.out_last   (m_tlast)
	);

endmodule

@@ rtl/core/sha1_chk.sv @@
// ----------------------------------------------------------------------------
// sha1_chk
// port-level checks on the digest output sequence
// ----------------------------------------------------------------------------
module sha1_chk (
	input logic        clk,
	input logic        arst_n,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [31:0] m_tdata,
	input logic [2:0]  m_tuser,
	input logic        m_tlast
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("output item changed while stalled");

	a_last_idx: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tlast == (m_tuser == 3'd4)))
		else $error("last flag does not match word index");

	a_idx_step: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tready && !m_tlast |=>
			m_tvalid && (m_tuser == $past(m_tuser) + 3'd1))
		else $error("digest words not consecutive");

	a_first_idx: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> (m_tuser == 3'd0))
		else $error("digest does not start at word zero");

endmodule

bind sha1_message_digest sha1_chk u_sha1_chk (
	.clk      (clk),
	.arst_n   (arst_n),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser),
	.m_tlast  (m_tlast)
);
